// ===== hw/rtl/vsrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrp_pkg
// Shared types and constants for the video scroll register port.
// ----------------------------------------------------------------------------
package vsrp_pkg;

    localparam int SPRITE_MEM_DEPTH = 256;
    localparam int SPR_AW           = $clog2(SPRITE_MEM_DEPTH);

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [2:0] {
        MODE_READ       = 3'd0,
        MODE_WRITE      = 3'd1,
        MODE_SET_FLAGS  = 3'd2,
        MODE_CLR_FLAGS  = 3'd3,
        MODE_RENDER_CPY = 3'd4,
        MODE_FRAME_END  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_SPR_ADDR = 3'd3,
        REG_SPR_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } reg_idx_t;

    localparam logic [14:0] CTRL_NT_MASK    = 15'h0c00;
    localparam logic [14:0] SCROLL_Y_MASK   = 15'h73e0;
    localparam logic [14:0] ADDR_HI_MASK    = 15'h3f00;
    localparam logic [14:0] A12_BIT         = 15'h1000;
    localparam logic [14:0] FRAME_NT_FLIP   = 15'h0400;
    localparam logic [14:0] FRAME_WRAP_SUB  = 15'h001e;
    localparam logic [14:0] FRAME_STEP      = 15'h0002;
    localparam logic [7:0]  FRAME_WRAP_LOW  = 8'hfe;
    localparam logic [7:0]  SPR_ATTR_MASK   = 8'he3;
    localparam logic [7:0]  STATUS_CLR_MASK = 8'he0;
    localparam logic [7:0]  STATUS_VBLANK   = 8'h80;
    localparam logic [1:0]  SPR_ATTR_SLOT   = 2'd2;
    localparam int          RENDER_EN_BIT   = 3;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] reg_index;
        logic [2:0] mode;
    } item_t;

    typedef struct packed {
        logic [2:0]  fine_scroll_x;
        logic [14:0] current_address;
        logic        a12_rise;
        logic [7:0]  read_data;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [SPR_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [SPR_AW-1:0] raddr;
    } spr_req_t;

endpackage

// ===== hw/rtl/vsrp_sprite_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrp_sprite_ram
// Sprite memory with per-entry valid bits; registered read, zero if unwritten.
// ----------------------------------------------------------------------------
module vsrp_sprite_ram (
    input  logic              clk,
    input  logic              rst_n,
    input  vsrp_pkg::spr_req_t req,
    output logic [7:0]        rdata
);
    import vsrp_pkg::*;

    logic [7:0]                  mem_reg [SPRITE_MEM_DEPTH];
    logic [SPRITE_MEM_DEPTH-1:0] valid_reg;
    logic [7:0]                  rd_reg;
    logic                        rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        if (req.we && (req.waddr == req.raddr))
        begin
            rd_reg <= req.wdata;
        end
        else
        begin
            rd_reg <= mem_reg[req.raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.waddr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[req.raddr] || (req.we && (req.waddr == req.raddr));
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : 8'h00;

endmodule

// ===== hw/rtl/vsrp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsrp_core
// Register file, scroll/address latches and per-item update logic.
// ----------------------------------------------------------------------------
module vsrp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  vsrp_pkg::item_t   item,
    output vsrp_pkg::result_t result
);
    import vsrp_pkg::*;

    logic [7:0]        control_reg, control_next;
    logic [7:0]        mask_reg, mask_next;
    logic [7:0]        status_reg, status_next;
    logic [SPR_AW-1:0] spr_addr_reg, spr_addr_next;
    logic              toggle_reg, toggle_next;
    logic [14:0]       temp_reg, temp_next;
    logic [14:0]       cur_reg, cur_next;
    logic [2:0]        fine_x_reg, fine_x_next;
    logic [7:0]        spr_rdata;
    logic [7:0]        rd;
    logic              rise;
    logic [14:0]       t;
    logic [14:0]       d15;
    spr_req_t          spr_req;

    assign d15 = {7'd0, item.data};

    always_comb
    begin
        control_next  = control_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        spr_addr_next = spr_addr_reg;
        toggle_next   = toggle_reg;
        temp_next     = temp_reg;
        cur_next      = cur_reg;
        fine_x_next   = fine_x_reg;
        rd            = 8'h00;
        rise          = 1'b0;
        t             = temp_reg;
        spr_req.we    = 1'b0;
        spr_req.waddr = spr_addr_reg;
        spr_req.wdata = item.data;
        if (fire)
        begin
            case (item.mode)
                MODE_READ:
                begin
                    if (item.reg_index == REG_STATUS)
                    begin
                        rd          = status_reg;
                        status_next = status_reg & ~STATUS_VBLANK;
                        toggle_next = 1'b0;
                    end
                    else if (item.reg_index == REG_SPR_DATA)
                    begin
                        rd = (spr_addr_reg[1:0] == SPR_ATTR_SLOT) ? (spr_rdata & SPR_ATTR_MASK)
                                                                  : spr_rdata;
                    end
                end
                MODE_WRITE:
                begin
                    unique case (item.reg_index)
                        REG_CTRL:
                        begin
                            control_next = item.data;
                            temp_next    = (t & ~CTRL_NT_MASK) | {3'd0, item.data[1:0], 10'd0};
                        end
                        REG_MASK:
                        begin
                            mask_next = item.data;
                        end
                        REG_SPR_ADDR:
                        begin
                            spr_addr_next = item.data[SPR_AW-1:0];
                        end
                        REG_SPR_DATA:
                        begin
                            spr_req.we    = 1'b1;
                            spr_addr_next = SPR_AW'(spr_addr_reg + 1'b1);
                        end
                        REG_SCROLL:
                        begin
                            if (toggle_reg)
                            begin
                                temp_next = (t & ~SCROLL_Y_MASK)
                                          | {item.data[2:0], 2'd0, item.data[7:3], 5'd0};
                            end
                            else
                            begin
                                fine_x_next = item.data[2:0];
                                temp_next   = {t[14:5], item.data[7:3]};
                            end
                            toggle_next = ~toggle_reg;
                        end
                        REG_ADDR:
                        begin
                            if (toggle_reg)
                            begin
                                temp_next = {t[14:8], item.data};
                                cur_next  = {t[14:8], item.data};
                                rise      = t[12] & ~cur_reg[12];
                            end
                            else
                            begin
                                temp_next = {1'b0, t[13:8] & 6'd0, t[7:0]}
                                          | ((d15 << 8) & ADDR_HI_MASK);
                            end
                            toggle_next = ~toggle_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MODE_SET_FLAGS:
                begin
                    status_next = status_reg | item.data;
                end
                MODE_CLR_FLAGS:
                begin
                    status_next = status_reg & ~STATUS_CLR_MASK;
                end
                MODE_RENDER_CPY:
                begin
                    if (mask_reg[RENDER_EN_BIT])
                    begin
                        cur_next = temp_reg;
                    end
                end
                MODE_FRAME_END:
                begin
                    if (mask_reg[RENDER_EN_BIT])
                    begin
                        if (cur_reg[7:0] < FRAME_WRAP_LOW)
                        begin
                            cur_next = cur_reg + FRAME_STEP;
                        end
                        else
                        begin
                            cur_next = (cur_reg ^ FRAME_NT_FLIP) - FRAME_WRAP_SUB;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        spr_req.raddr = spr_addr_next;
    end

    assign result.read_data       = rd;
    assign result.a12_rise        = rise;
    assign result.current_address = cur_next;
    assign result.fine_scroll_x   = fine_x_next;

    vsrp_sprite_ram u_sprite_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (spr_req),
        .rdata (spr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg  <= 8'h00;
            mask_reg     <= 8'h00;
            status_reg   <= STATUS_VBLANK;
            spr_addr_reg <= '0;
            toggle_reg   <= 1'b0;
            temp_reg     <= 15'd0;
            cur_reg      <= 15'd0;
            fine_x_reg   <= 3'd0;
        end
        else
        begin
            control_reg  <= control_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            spr_addr_reg <= spr_addr_next;
            toggle_reg   <= toggle_next;
            temp_reg     <= temp_next;
            cur_reg      <= cur_next;
            fine_x_reg   <= fine_x_next;
        end
    end

    a_status_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_READ && item.reg_index == REG_STATUS)
        |=> (!status_reg[7] && !toggle_reg))
        else $error("status read did not clear vblank and toggle");

    a_spr_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == MODE_WRITE && item.reg_index == REG_SPR_DATA)
        |=> (spr_addr_reg == SPR_AW'($past(spr_addr_reg) + 1'b1)))
        else $error("sprite address did not advance");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(cur_reg) && $stable(temp_reg) && $stable(toggle_reg)))
        else $error("address state changed without an item");

    a_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.a12_rise)
        |-> (item.mode == MODE_WRITE && item.reg_index == REG_ADDR && toggle_reg
             && result.current_address[12] && !cur_reg[12]))
        else $error("a12 rise outside a second address write");

endmodule

// ===== hw/rtl/video_scroll_register_port_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_scroll_register_port_top
// CPU-facing register port: stream in, input register, core, result register.
// ----------------------------------------------------------------------------
// One item is accepted every clock, and a stalled result side holds the pipe;
// each result passes through the input register, then the result register.
// The sprite memory is read ahead at the next sprite address, so data reads
// keep full rate. Unwritten sprite entries read as zero through per-entry
// valid bits cleared at reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module video_scroll_register_port_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // mode[2:0], reg_index[5:3], data[13:6], zero[15:14]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // read_data[7:0], a12_rise[8],
                                       // current_address[23:9], fine_scroll_x[26:24],
                                       // zero[31:27]
);
    import vsrp_pkg::*;

    logic    in_vld_reg;
    item_t   in_reg;
    logic    out_vld_reg;
    result_t out_reg;
    logic    fire;
    result_t result;

    assign fire          = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg <= s_axis_tdata[13:0];
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

    vsrp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_reg),
        .result (result)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'd0, out_reg};

endmodule

// ===== verif/tb_video_scroll_register_port_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_scroll_register_port_top
// Self-checking bench for the video scroll register port.
// ----------------------------------------------------------------------------
// Register accesses and events are streamed into the port. A predictor in the
// bench keeps its own copy of the control, mask, status, sprite, toggle and
// address state and queues the result expected for every accepted item.
// Each returned result is compared field by field with the oldest entry.
// Directed corners come first, then randomised access sequences (scroll and
// address pairs, sprite traffic, status flags, render events, plain noise),
// then a long result-side hold-off that backs the pipe up into the input.
// ----------------------------------------------------------------------------
module tb_video_scroll_register_port_top;
    import vsrp_pkg::*;

    localparam logic [2:0] MODE_UNUSED_6    = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7    = 3'd7;
    localparam int         RANDOM_ITEMS     = 400;
    localparam int         LONG_HOLD_CYCLES = 200;
    localparam int         DRAIN_LIMIT      = 5000;
    localparam int         TAIL_CYCLES      = 8;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;

    video_scroll_register_port_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [7:0]  status_q;
    logic [7:0]  spr_addr_q;
    logic [7:0]  spr_mem_q [SPRITE_MEM_DEPTH];
    logic        toggle_q;
    logic [14:0] temp_addr_q;
    logic [14:0] cur_addr_q;
    logic [2:0]  fine_x_q;

    result_t expected_results[$];

    int errors          = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int reads_seen      = 0;
    int a12_rises       = 0;
    int frame_wraps     = 0;
    bit burst           = 1'b0;
    bit long_hold_req   = 1'b0;

    task automatic reset_port_state();
        ctrl_q      = '0;
        mask_q      = '0;
        status_q    = STATUS_VBLANK;
        spr_addr_q  = '0;
        toggle_q    = 1'b0;
        temp_addr_q = '0;
        cur_addr_q  = '0;
        fine_x_q    = '0;
        for (int i = 0; i < SPRITE_MEM_DEPTH; i++)
        begin
            spr_mem_q[i] = '0;
        end
    endtask

    task automatic predict_port_access(input logic [2:0] mode, input logic [2:0] idx,
                                       input logic [7:0] d);
        result_t     r;
        logic [14:0] t;
        logic        was_low;
        r = '0;
        t = temp_addr_q;
        case (mode)
            MODE_READ:
            begin
                reads_seen++;
                if (idx == REG_STATUS)
                begin
                    r.read_data = status_q;
                    status_q    = status_q & ~STATUS_VBLANK;
                    toggle_q    = 1'b0;
                end
                else if (idx == REG_SPR_DATA)
                begin
                    r.read_data = spr_mem_q[spr_addr_q];
                    if (spr_addr_q[1:0] == SPR_ATTR_SLOT)
                        r.read_data = r.read_data & SPR_ATTR_MASK;
                end
            end
            MODE_WRITE:
            begin
                case (idx)
                    REG_CTRL:
                    begin
                        ctrl_q    = d;
                        t[11:10]  = d[1:0];
                    end
                    REG_MASK:     mask_q = d;
                    REG_SPR_ADDR: spr_addr_q = d;
                    REG_SPR_DATA:
                    begin
                        spr_mem_q[spr_addr_q] = d;
                        spr_addr_q            = spr_addr_q + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (toggle_q)
                            t = (t & ~SCROLL_Y_MASK) | {d[2:0], 2'b00, d[7:3], 5'b00000};
                        else
                        begin
                            fine_x_q = d[2:0];
                            t[4:0]   = d[7:3];
                        end
                        toggle_q = ~toggle_q;
                    end
                    REG_ADDR:
                    begin
                        if (toggle_q)
                        begin
                            was_low     = ~cur_addr_q[12];
                            t[7:0]      = d;
                            cur_addr_q  = t;
                            r.a12_rise  = cur_addr_q[12] & was_low;
                            if (r.a12_rise)
                                a12_rises++;
                        end
                        else
                            t[14:8] = {1'b0, d[5:0]};
                        toggle_q = ~toggle_q;
                    end
                    default: ;
                endcase
                temp_addr_q = t;
            end
            MODE_SET_FLAGS:  status_q = status_q | d;
            MODE_CLR_FLAGS:  status_q = status_q & ~STATUS_CLR_MASK;
            MODE_RENDER_CPY:
            begin
                if (mask_q[RENDER_EN_BIT])
                    cur_addr_q = temp_addr_q;
            end
            MODE_FRAME_END:
            begin
                if (mask_q[RENDER_EN_BIT])
                begin
                    if (cur_addr_q[7:0] < FRAME_WRAP_LOW)
                        cur_addr_q = cur_addr_q + FRAME_STEP;
                    else
                    begin
                        cur_addr_q = (cur_addr_q ^ FRAME_NT_FLIP) - FRAME_WRAP_SUB;
                        frame_wraps++;
                    end
                end
            end
            default: ;
        endcase
        r.current_address = cur_addr_q;
        r.fine_scroll_x   = fine_x_q;
        expected_results.push_back(r);
    endtask

    task automatic send_item(input logic [2:0] mode, input logic [2:0] idx,
                             input logic [7:0] d);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, d, idx, mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_port_access(mode, idx, d);
        items_sent++;
    endtask

    // Result side: draw a stall per item, honour a long hold-off on request.
    initial
    begin
        int stall;
        forever
        begin
            if (long_hold_req)
            begin
                stall         = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            else
                stall = burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[26:0]);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.read_data, got.read_data);
                    errors++;
                end
                if (got.a12_rise !== want.a12_rise)
                begin
                    $display("%0t: a12_rise expected %h actual %h", $time,
                             want.a12_rise, got.a12_rise);
                    errors++;
                end
                if (got.current_address !== want.current_address)
                begin
                    $display("%0t: current_address expected %h actual %h", $time,
                             want.current_address, got.current_address);
                    errors++;
                end
                if (got.fine_scroll_x !== want.fine_scroll_x)
                begin
                    $display("%0t: fine_scroll_x expected %h actual %h", $time,
                             want.fine_scroll_x, got.fine_scroll_x);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed_corners();
        // status after reset, then flag set and clear
        send_item(MODE_READ, REG_STATUS, 8'h00);
        send_item(MODE_READ, REG_STATUS, 8'hff);
        send_item(MODE_SET_FLAGS, REG_DATA, 8'hff);
        send_item(MODE_READ, REG_STATUS, 8'h00);
        send_item(MODE_CLR_FLAGS, REG_CTRL, 8'hff);
        send_item(MODE_READ, REG_STATUS, 8'h00);
        // full-scale scroll and address writes; second address write raises bit 12
        send_item(MODE_WRITE, REG_CTRL, 8'hff);
        send_item(MODE_WRITE, REG_SCROLL, 8'hff);
        send_item(MODE_WRITE, REG_SCROLL, 8'hff);
        send_item(MODE_WRITE, REG_ADDR, 8'hff);
        send_item(MODE_WRITE, REG_ADDR, 8'h00);
        send_item(MODE_WRITE, REG_ADDR, 8'h00);
        send_item(MODE_WRITE, REG_ADDR, 8'hfe);
        // render events, first disabled, then enabled with a row wrap
        send_item(MODE_FRAME_END, REG_ADDR, 8'h00);
        send_item(MODE_WRITE, REG_MASK, 8'h08);
        send_item(MODE_FRAME_END, REG_STATUS, 8'hff);
        send_item(MODE_RENDER_CPY, REG_MASK, 8'h00);
        // sprite memory: attribute slot masking and address wrap
        send_item(MODE_WRITE, REG_SPR_ADDR, 8'hfe);
        send_item(MODE_WRITE, REG_SPR_DATA, 8'hff);
        send_item(MODE_WRITE, REG_SPR_DATA, 8'h00);
        send_item(MODE_WRITE, REG_SPR_ADDR, 8'hfe);
        send_item(MODE_READ, REG_SPR_DATA, 8'h00);
        // write-only reads, ignored writes, undefined modes
        send_item(MODE_READ, REG_CTRL, 8'hff);
        send_item(MODE_READ, REG_DATA, 8'h00);
        send_item(MODE_WRITE, REG_STATUS, 8'hff);
        send_item(MODE_WRITE, REG_DATA, 8'hff);
        send_item(MODE_UNUSED_6, REG_ADDR, 8'hff);
        send_item(MODE_UNUSED_7, REG_SCROLL, 8'hff);
    endtask

    task automatic test_random_traffic();
        int         start;
        int         kind;
        int         n;
        logic [7:0] d;
        logic [7:0] base;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            burst = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 9);
            case (kind)
                0, 1:
                begin
                    if ($urandom_range(0, 1))
                        send_item(MODE_READ, REG_STATUS, 8'($urandom_range(0, 255)));
                    send_item(MODE_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                    send_item(MODE_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                end
                2, 3:
                begin
                    if ($urandom_range(0, 1))
                        send_item(MODE_READ, REG_STATUS, 8'($urandom_range(0, 255)));
                    send_item(MODE_WRITE, REG_ADDR, 8'($urandom_range(0, 255)));
                    d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hf8, 8'hff))
                                                    : 8'($urandom_range(0, 255));
                    send_item(MODE_WRITE, REG_ADDR, d);
                end
                4:
                begin
                    d = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 3) != 0)
                        d[RENDER_EN_BIT] = 1'b1;
                    send_item(MODE_WRITE, REG_MASK, d);
                    n = $urandom_range(1, 6);
                    repeat (n)
                    begin
                        send_item($urandom_range(0, 1) ? MODE_FRAME_END : MODE_RENDER_CPY,
                                  3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                    end
                end
                5:
                begin
                    base = 8'($urandom_range(0, 255));
                    n    = $urandom_range(1, 4);
                    send_item(MODE_WRITE, REG_SPR_ADDR, base);
                    repeat (n) send_item(MODE_WRITE, REG_SPR_DATA, 8'($urandom_range(0, 255)));
                    for (int i = 0; i < n; i++)
                    begin
                        send_item(MODE_WRITE, REG_SPR_ADDR, base + i[7:0]);
                        send_item(MODE_READ, REG_SPR_DATA, 8'($urandom_range(0, 255)));
                    end
                end
                6:
                begin
                    send_item(MODE_SET_FLAGS, 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255)));
                    send_item(MODE_READ, REG_STATUS, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1))
                        send_item(MODE_CLR_FLAGS, 3'($urandom_range(0, 7)),
                                  8'($urandom_range(0, 255)));
                    send_item(MODE_READ, REG_STATUS, 8'($urandom_range(0, 255)));
                end
                7:
                    send_item(MODE_WRITE, REG_CTRL, 8'($urandom_range(0, 255)));
                default:
                begin
                    n = $urandom_range(1, 4);
                    repeat (n)
                    begin
                        send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                  8'($urandom_range(0, 255)));
                    end
                end
            endcase
        end
        burst = 1'b0;
    endtask

    task automatic test_input_stall();
        burst         = 1'b1;
        long_hold_req = 1'b1;
        repeat (30)
        begin
            send_item($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
                      $urandom_range(0, 1) ? REG_SPR_DATA : REG_ADDR,
                      8'($urandom_range(0, 255)));
        end
        burst = 1'b0;
    endtask

    initial
    begin
        int waited;
        reset_port_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_random_traffic();
        test_input_stall();
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (expected_results.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            errors++;
        end
        $display("Covered %0d items and %0d results: %0d reads, %0d bit-12 rises,",
                 items_sent, results_checked, reads_seen, a12_rises);
        $display("%0d frame-end row wraps, random stalls on both sides and one long hold-off.",
                 frame_wraps);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule
